// ----- src/card_and_pin_access_controller_macros.svh -----
// Assertion macros shared by the card and PIN access controller RTL.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef CARD_AND_PIN_ACCESS_CONTROLLER_MACROS_SVH
`define CARD_AND_PIN_ACCESS_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define CPAC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("card_and_pin_access_controller: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPAC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("card_and_pin_access_controller: assertion failed");

`else

`define CPAC_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CPAC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- src/cpac_pkg.sv -----
// Package for the card and PIN access controller: payload structs, codes and constants.
// No dependencies; every module of the block imports it.
`default_nettype none

package cpac_pkg;

    // Number of PIN digits collected before the compare.
    localparam int PIN_DIGITS = 4;
    // Digit counter width; the held count stays below PIN_DIGITS.
    localparam int CNT_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;

    localparam int TICK_W      = 24;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Register reset values.
    localparam logic [31:0]       RST_CARD_A_ID  = 32'd3805971974;
    localparam logic [31:0]       RST_CARD_B_ID  = 32'd3259988742;
    localparam logic [15:0]       RST_CARD_A_PIN = 16'd4660;
    localparam logic [15:0]       RST_CARD_B_PIN = 16'd17185;
    localparam logic [TICK_W-1:0] RST_TIMEOUT    = 24'd10000;

    // Key codes and card length that can match.
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_STAR      = 4'd10;
    localparam logic [3:0] KEY_HASH      = 4'd11;
    localparam logic [3:0] CARD_ID_LEN   = 4'd4;

    // Servo pulse widths in microseconds.
    localparam logic [10:0] SERVO_CLOSED_US = 11'd1000;
    localparam logic [10:0] SERVO_OPEN_US   = 11'd2000;

    typedef enum logic [1:0] {
        MODE_ERROR = 2'd0,
        MODE_WAIT  = 2'd1,
        MODE_ENTRY = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CARD   = 3'd1,
        OP_KEY    = 3'd2,
        OP_BUTTON = 3'd3,
        OP_FAULT  = 3'd4
    } opcode_t;

    typedef enum logic [3:0] {
        ST_NONE      = 4'd0,
        ST_CARD_OK   = 4'd1,
        ST_DIGIT     = 4'd2,
        ST_CLEARED   = 4'd3,
        ST_GRANTED   = 4'd4,
        ST_DENIED    = 4'd5,
        ST_CANCELLED = 4'd6,
        ST_FAULT     = 4'd7,
        ST_TOGGLED   = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        REG_CARD_A_ID  = 3'd0,
        REG_CARD_B_ID  = 3'd1,
        REG_CARD_A_PIN = 3'd2,
        REG_CARD_B_PIN = 3'd3,
        REG_TIMEOUT    = 3'd4
    } cfg_reg_t;

    // One input event.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] card_id;
        logic [3:0]  card_id_bytes;
        logic [3:0]  key_code;
    } evt_t;

    // One result.
    typedef struct packed {
        logic [3:0]  event_status;
        logic        door_is_open;
        logic [2:0]  digits_held;
        logic [10:0] servo_pulse_us;
    } res_t;

    // Configuration as seen by the event core.
    typedef struct packed {
        logic [31:0]       card_a_id;
        logic [31:0]       card_b_id;
        logic [15:0]       card_a_pin;
        logic [15:0]       card_b_pin;
        logic [TICK_W-1:0] entry_timeout_ticks;
    } cfg_t;

    // Expected digit at position idx of a BCD PIN; zero past the top nibble.
    function automatic logic [3:0] pin_digit(input logic [15:0] pin, input int unsigned idx);
        int unsigned sh;
        sh = 4 * (PIN_DIGITS - 1 - idx);
        if (sh < 16) begin
            return 4'(pin >> sh);
        end
        return 4'd0;
    endfunction

endpackage

`default_nettype wire

// ----- src/card_and_pin_access_controller.sv -----
// Top level of the card and PIN access controller: input register, event core,
// result register and APB configuration registers. Depends on cpac_pkg and the macros header.
// Every event (tick, card read, key press, button press or reader fault) produces exactly one
// result. The block takes one transaction per clock cycle while the consumer keeps m_ready
// high. An accepted event waits in the input register until the result register can take
// its result; then the single-pass event core updates the lock state and loads the result
// register, which holds the result until the consumer takes it. The only stalls come from
// a consumer that holds m_ready low.
// Configuration registers are to be written through the APB port while no events are in
// flight; the user must keep to this, the block itself does not enforce it.
`default_nettype none

`include "card_and_pin_access_controller_macros.svh"

module card_and_pin_access_controller
    import cpac_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Event channel.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire evt_t                  s_data,
    // Result channel.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output res_t                       m_data,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t cfg;
    evt_t in_data;
    res_t core_res;
    logic in_valid;
    logic advance;

    // An event moves into the core when the result register can take its result.
    assign advance = in_valid && (!m_valid || m_ready);

    cpac_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpac_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .advance  (advance),
        .in_valid (in_valid),
        .in_data  (in_data)
    );

    cpac_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (advance),
        .evt     (in_data),
        .res     (core_res)
    );

    cpac_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .res_in  (core_res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // An accepted transaction is held in the input register on the next cycle.
    `CPAC_ASSERT_NEXT(a_accept_held, aclk, aresetn, s_valid && s_ready, in_valid)

    // A processed event always leaves a result waiting on the next cycle.
    `CPAC_ASSERT_NEXT(a_result_follows, aclk, aresetn, advance, m_valid)

    // The held digit count never reaches the full PIN length.
    `CPAC_ASSERT_IMPL(a_digits_below_len, aclk, aresetn, m_valid,
        32'(m_data.digits_held) < PIN_DIGITS)

    // Grants and cancellations leave the door open with no digits held.
    `CPAC_ASSERT_IMPL(a_open_on_grant, aclk, aresetn,
        m_valid && (m_data.event_status == ST_GRANTED || m_data.event_status == ST_CANCELLED),
        m_data.door_is_open && m_data.digits_held == 3'd0)

endmodule

`default_nettype wire

// ----- src/cpac_regs.sv -----
// APB configuration registers of the card and PIN access controller.
// Depends on cpac_pkg for register indexes, reset values and the cfg_t struct.
`default_nettype none

module cpac_regs
    import cpac_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [31:0]       card_a_id_reg;
    logic [31:0]       card_b_id_reg;
    logic [15:0]       card_a_pin_reg;
    logic [15:0]       card_b_pin_reg;
    logic [TICK_W-1:0] timeout_reg;
    logic [2:0]        reg_index;
    logic              wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            card_a_id_reg  <= RST_CARD_A_ID;
            card_b_id_reg  <= RST_CARD_B_ID;
            card_a_pin_reg <= RST_CARD_A_PIN;
            card_b_pin_reg <= RST_CARD_B_PIN;
            timeout_reg    <= RST_TIMEOUT;
        end else if (wr_en) begin
            case (reg_index)
                REG_CARD_A_ID:  card_a_id_reg  <= pwdata;
                REG_CARD_B_ID:  card_b_id_reg  <= pwdata;
                REG_CARD_A_PIN: card_a_pin_reg <= pwdata[15:0];
                REG_CARD_B_PIN: card_b_pin_reg <= pwdata[15:0];
                REG_TIMEOUT:    timeout_reg    <= pwdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data, zero-extended to the bus width.
    always_comb begin
        case (reg_index)
            REG_CARD_A_ID:  prdata = card_a_id_reg;
            REG_CARD_B_ID:  prdata = card_b_id_reg;
            REG_CARD_A_PIN: prdata = APB_DATA_W'(card_a_pin_reg);
            REG_CARD_B_PIN: prdata = APB_DATA_W'(card_b_pin_reg);
            REG_TIMEOUT:    prdata = APB_DATA_W'(timeout_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.card_a_id           = card_a_id_reg;
    assign cfg.card_b_id           = card_b_id_reg;
    assign cfg.card_a_pin          = card_a_pin_reg;
    assign cfg.card_b_pin          = card_b_pin_reg;
    assign cfg.entry_timeout_ticks = timeout_reg;

endmodule

`default_nettype wire

// ----- src/cpac_in_reg.sv -----
// Input register stage: holds one accepted event until the core processes it.
// Depends on cpac_pkg for the evt_t payload struct.
`default_nettype none

module cpac_in_reg
    import cpac_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire evt_t s_data,
    input  wire logic advance,
    output logic      in_valid,
    output evt_t      in_data
);

    logic in_valid_reg;
    evt_t in_data_reg;

    // Free when empty or when the held event moves on this cycle.
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_data  = in_data_reg;

endmodule

`default_nettype wire

// ----- src/cpac_core.sv -----
// Event core: mode state machine, door latch, PIN digit store and entry timer.
// Depends on cpac_pkg for codes, constants, structs and the PIN digit function.
`default_nettype none

module cpac_core
    import cpac_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic fire,
    input  wire evt_t evt,
    output res_t      res
);

    mode_t             mode_reg, mode_next;
    logic              door_reg, door_next;
    logic              sel_reg, sel_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [TICK_W-1:0] elapsed_inc;
    logic [3:0]        digit_reg [PIN_DIGITS];
    logic              digit_wr;
    logic              pin_ok;
    logic [15:0]       pin_sel;
    logic              card_len_ok;
    status_t           status;

    // Control state updates once per processed event.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_WAIT;
            door_reg    <= 1'b0;
            sel_reg     <= 1'b0;
            cnt_reg     <= '0;
            elapsed_reg <= '0;
        end else if (fire) begin
            mode_reg    <= mode_next;
            door_reg    <= door_next;
            sel_reg     <= sel_next;
            cnt_reg     <= cnt_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Digit store; entries are only compared after being written.
    always_ff @(posedge aclk) begin
        if (fire && digit_wr) begin
            digit_reg[cnt_reg] <= evt.key_code;
        end
    end

    // PIN compare with the incoming key as the last digit.
    always_comb begin
        pin_sel = sel_reg ? cfg.card_b_pin : cfg.card_a_pin;
        pin_ok  = 1'b1;
        for (int i = 0; i < PIN_DIGITS; i++) begin
            if (i == PIN_DIGITS - 1) begin
                if (evt.key_code != pin_digit(pin_sel, i)) begin
                    pin_ok = 1'b0;
                end
            end else if (digit_reg[i] != pin_digit(pin_sel, i)) begin
                pin_ok = 1'b0;
            end
        end
    end

    // Saturating tick count and card length check.
    assign elapsed_inc = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + TICK_W'(1);
    assign card_len_ok = (evt.card_id_bytes == CARD_ID_LEN);

    // Next state and status for the event held in the input register.
    always_comb begin
        mode_next    = mode_reg;
        door_next    = door_reg;
        sel_next     = sel_reg;
        cnt_next     = cnt_reg;
        elapsed_next = elapsed_reg;
        digit_wr     = 1'b0;
        status       = ST_NONE;

        case (evt.opcode)
            OP_TICK: begin
                if (mode_reg == MODE_ENTRY) begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > cfg.entry_timeout_ticks) begin
                        status    = ST_DENIED;
                        cnt_next  = '0;
                        sel_next  = 1'b0;
                        mode_next = MODE_WAIT;
                    end
                end
            end
            OP_CARD: begin
                if (mode_reg == MODE_WAIT) begin
                    cnt_next = '0;
                    sel_next = 1'b0;
                    if (!door_reg) begin
                        if (card_len_ok && evt.card_id == cfg.card_a_id) begin
                            status       = ST_CARD_OK;
                            elapsed_next = '0;
                            mode_next    = MODE_ENTRY;
                        end else if (card_len_ok && evt.card_id == cfg.card_b_id) begin
                            sel_next     = 1'b1;
                            status       = ST_CARD_OK;
                            elapsed_next = '0;
                            mode_next    = MODE_ENTRY;
                        end else begin
                            status = ST_DENIED;
                        end
                    end
                end
            end
            OP_KEY: begin
                if (mode_reg == MODE_ENTRY) begin
                    if (evt.key_code <= KEY_DIGIT_MAX) begin
                        if (32'(cnt_reg) == PIN_DIGITS - 1) begin
                            // Last digit: compare and leave entry either way.
                            if (pin_ok) begin
                                status    = ST_GRANTED;
                                door_next = 1'b1;
                            end else begin
                                status = ST_DENIED;
                            end
                            cnt_next  = '0;
                            sel_next  = 1'b0;
                            mode_next = MODE_WAIT;
                        end else begin
                            digit_wr = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                            status   = ST_DIGIT;
                        end
                    end else if (evt.key_code == KEY_STAR) begin
                        cnt_next = '0;
                        status   = ST_CLEARED;
                    end else if (evt.key_code == KEY_HASH) begin
                        // An early compare never has enough digits to match.
                        status    = ST_DENIED;
                        cnt_next  = '0;
                        sel_next  = 1'b0;
                        mode_next = MODE_WAIT;
                    end
                end
            end
            OP_BUTTON: begin
                door_next = !door_reg;
                status    = ST_TOGGLED;
                if (!door_reg && mode_reg == MODE_ENTRY) begin
                    cnt_next  = '0;
                    sel_next  = 1'b0;
                    mode_next = MODE_WAIT;
                    status    = ST_CANCELLED;
                end
            end
            OP_FAULT: begin
                cnt_next  = '0;
                sel_next  = 1'b0;
                mode_next = MODE_ERROR;
                status    = ST_FAULT;
            end
            default: begin
            end
        endcase
    end

    // Result fields reflect the state after the event.
    assign res.event_status   = status;
    assign res.door_is_open   = door_next;
    assign res.digits_held    = 3'(cnt_next);
    assign res.servo_pulse_us = door_next ? SERVO_OPEN_US : SERVO_CLOSED_US;

endmodule

`default_nettype wire

// ----- src/cpac_out_reg.sv -----
// Result register stage: holds one result until the consumer takes it.
// Depends on cpac_pkg for the res_t payload struct.
`default_nettype none

module cpac_out_reg
    import cpac_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic load,
    input  wire res_t res_in,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_data
);

    logic m_valid_reg;
    res_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= res_in;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- verif/card_and_pin_access_controller_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the card and PIN access controller: directed and random lock
// events go in, and every result is checked against a lock model kept in this file.
// Depends on cpac_pkg and the card_and_pin_access_controller RTL.

module card_and_pin_access_controller_test;
    import cpac_pkg::*;

    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          PRINT_LIMIT  = 20;
    localparam logic [2:0]  OP_UNDEFINED = 3'd7;
    localparam logic [3:0]  KEY_LETTER_A = 4'd12;
    localparam logic [3:0]  KEY_LETTER_D = 4'd15;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    evt_t                  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    res_t                  m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Lock settings as last written through the configuration port.
    logic [31:0]       set_card_a_id  = RST_CARD_A_ID;
    logic [31:0]       set_card_b_id  = RST_CARD_B_ID;
    logic [15:0]       set_card_a_pin = RST_CARD_A_PIN;
    logic [15:0]       set_card_b_pin = RST_CARD_B_PIN;
    logic [TICK_W-1:0] set_timeout    = RST_TIMEOUT;

    // Lock state as the model sees it.
    mode_t             lock_mode    = MODE_WAIT;
    logic              door_latched = 1'b0;
    logic              card_b_sel   = 1'b0;
    logic [3:0]        key_buf [PIN_DIGITS];
    int unsigned       key_count    = 0;
    logic [TICK_W-1:0] entry_ticks  = '0;

    evt_t        event_q [$];
    res_t        lock_result_q [$];
    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count  = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned status_seen [9];

    card_and_pin_access_controller dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Print one line per mismatch, up to a limit, and count all of them.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                     what, got, want, checked_count);
        end
    endtask

    // Forget the collected digits and the selected card.
    function automatic void drop_entry();
        for (int i = 0; i < PIN_DIGITS; i++) begin
            key_buf[i] = 4'd0;
        end
        key_count  = 0;
        card_b_sel = 1'b0;
    endfunction

    // True only when a full PIN has been collected and equals the selected card's PIN.
    function automatic logic pin_entered_ok();
        logic [15:0] pin;
        int unsigned sh;
        pin = card_b_sel ? set_card_b_pin : set_card_a_pin;
        if (key_count != PIN_DIGITS) begin
            return 1'b0;
        end
        for (int i = 0; i < PIN_DIGITS; i++) begin
            sh = 4 * (PIN_DIGITS - 1 - i);
            if (key_buf[i] != ((sh < 16) ? pin[sh +: 4] : 4'd0)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Apply one event to the lock model and return the result it should produce.
    function automatic res_t lock_step(input evt_t ev);
        status_t st;
        res_t    r;
        st = ST_NONE;
        case (ev.opcode)
            OP_TICK: begin
                if (lock_mode == MODE_ENTRY) begin
                    if (entry_ticks != TICK_MAX) begin
                        entry_ticks++;
                    end
                    if (entry_ticks > set_timeout) begin
                        st = ST_DENIED;
                        drop_entry();
                        lock_mode = MODE_WAIT;
                    end
                end
            end
            OP_CARD: begin
                if (lock_mode == MODE_WAIT) begin
                    drop_entry();
                    if (!door_latched) begin
                        if (ev.card_id_bytes == CARD_ID_LEN && ev.card_id == set_card_a_id) begin
                            st = ST_CARD_OK;
                        end else if (ev.card_id_bytes == CARD_ID_LEN &&
                                     ev.card_id == set_card_b_id) begin
                            st = ST_CARD_OK;
                            card_b_sel = 1'b1;
                        end else begin
                            st = ST_DENIED;
                        end
                        if (st == ST_CARD_OK) begin
                            entry_ticks = '0;
                            lock_mode   = MODE_ENTRY;
                        end
                    end
                end
            end
            OP_KEY: begin
                if (lock_mode == MODE_ENTRY) begin
                    if (ev.key_code <= KEY_DIGIT_MAX) begin
                        if (key_count < PIN_DIGITS) begin
                            key_buf[key_count] = ev.key_code;
                            key_count++;
                        end
                        st = ST_DIGIT;
                        // The last digit decides the entry either way.
                        if (key_count >= PIN_DIGITS) begin
                            if (pin_entered_ok()) begin
                                st = ST_GRANTED;
                                door_latched = 1'b1;
                            end else begin
                                st = ST_DENIED;
                            end
                            drop_entry();
                            lock_mode = MODE_WAIT;
                        end
                    end else if (ev.key_code == KEY_STAR) begin
                        key_count = 0;
                        st = ST_CLEARED;
                    end else if (ev.key_code == KEY_HASH) begin
                        if (pin_entered_ok()) begin
                            st = ST_GRANTED;
                            door_latched = 1'b1;
                        end else begin
                            st = ST_DENIED;
                        end
                        drop_entry();
                        lock_mode = MODE_WAIT;
                    end
                end
            end
            OP_BUTTON: begin
                door_latched = !door_latched;
                st = ST_TOGGLED;
                if (door_latched && lock_mode == MODE_ENTRY) begin
                    drop_entry();
                    lock_mode = MODE_WAIT;
                    st = ST_CANCELLED;
                end
            end
            OP_FAULT: begin
                drop_entry();
                lock_mode = MODE_ERROR;
                st = ST_FAULT;
            end
            default: begin
            end
        endcase
        r.event_status   = st;
        r.door_is_open   = door_latched;
        r.digits_held    = 3'(key_count);
        r.servo_pulse_us = door_latched ? SERVO_OPEN_US : SERVO_CLOSED_US;
        return r;
    endfunction

    // Event driver: predicts each accepted transaction and presents the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                lock_result_q.push_back(lock_step(s_data));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (event_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= event_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transaction against the oldest prediction.
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (lock_result_q.size() == 0) begin
                    report_mismatch("result with nothing expected", m_data, '0);
                end else begin
                    want = lock_result_q.pop_front();
                    if (m_data.event_status != want.event_status) begin
                        report_mismatch("event_status", m_data.event_status, want.event_status);
                    end
                    if (m_data.door_is_open != want.door_is_open) begin
                        report_mismatch("door_is_open", m_data.door_is_open, want.door_is_open);
                    end
                    if (m_data.digits_held != want.digits_held) begin
                        report_mismatch("digits_held", m_data.digits_held, want.digits_held);
                    end
                    if (m_data.servo_pulse_us != want.servo_pulse_us) begin
                        report_mismatch("servo_pulse_us", m_data.servo_pulse_us,
                                        want.servo_pulse_us);
                    end
                    if (want.event_status <= ST_TOGGLED) begin
                        status_seen[want.event_status]++;
                    end
                    checked_count++;
                end
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d results still expected.", lock_result_q.size());
            $display("FAIL card_and_pin_access_controller");
            $finish;
        end
    end

    // Wait until every queued event is accepted and every result has come back.
    task automatic wait_idle();
        while (accepted_count != queued_count || lock_result_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // Write one register, read it back, and update the model's copy.
    task automatic reg_write(input cfg_reg_t idx, input logic [31:0] value);
        logic [31:0] held;
        case (idx)
            REG_CARD_A_ID:  held = value;
            REG_CARD_B_ID:  held = value;
            REG_CARD_A_PIN: held = {16'd0, value[15:0]};
            REG_CARD_B_PIN: held = {16'd0, value[15:0]};
            default:        held = {8'd0, value[TICK_W-1:0]};
        endcase
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata != held) begin
            report_mismatch("register readback", prdata, held);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CARD_A_ID:  set_card_a_id  = held;
            REG_CARD_B_ID:  set_card_b_id  = held;
            REG_CARD_A_PIN: set_card_a_pin = held[15:0];
            REG_CARD_B_PIN: set_card_b_pin = held[15:0];
            default:        set_timeout    = held[TICK_W-1:0];
        endcase
    endtask

    task automatic set_lock(input logic [31:0] a_id, input logic [31:0] b_id,
                            input logic [15:0] a_pin, input logic [15:0] b_pin,
                            input logic [31:0] timeout);
        reg_write(REG_CARD_A_ID, a_id);
        reg_write(REG_CARD_B_ID, b_id);
        reg_write(REG_CARD_A_PIN, {16'd0, a_pin});
        reg_write(REG_CARD_B_PIN, {16'd0, b_pin});
        reg_write(REG_TIMEOUT, timeout);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] random_bcd();
        return {4'($urandom_range(9)), 4'($urandom_range(9)),
                4'($urandom_range(9)), 4'($urandom_range(9))};
    endfunction

    task automatic queue_event(input logic [2:0] op, input logic [31:0] id,
                               input logic [3:0] nbytes, input logic [3:0] key);
        evt_t ev;
        ev.opcode        = op;
        ev.card_id       = id;
        ev.card_id_bytes = nbytes;
        ev.key_code      = key;
        event_q.push_back(ev);
        queued_count++;
    endtask

    // Event of the given kind with the unused fields filled at random.
    task automatic queue_op(input logic [2:0] op);
        queue_event(op, $urandom, 4'($urandom_range(15)), 4'($urandom_range(15)));
    endtask

    // Any event except a reader fault, which would lock the block up for good.
    task automatic queue_noise();
        logic [2:0] op;
        do begin
            op = 3'($urandom_range(7));
        end while (op == OP_FAULT);
        queue_op(op);
    endtask

    // One card-and-PIN attempt, mostly well formed, sometimes broken off.
    task automatic queue_session();
        logic [31:0] id;
        logic [15:0] pin;
        logic [3:0]  nbytes;
        logic [3:0]  d;
        bit          right;
        int unsigned pick;
        int unsigned i;
        pick   = $urandom_range(99);
        nbytes = CARD_ID_LEN;
        if (pick < 45) begin
            id  = set_card_a_id;
            pin = set_card_a_pin;
        end else if (pick < 90) begin
            id  = set_card_b_id;
            pin = set_card_b_pin;
        end else begin
            id     = (pick < 95) ? set_card_a_id : $urandom;
            pin    = set_card_a_pin;
            nbytes = 4'($urandom_range(15));
        end
        if ($urandom_range(99) < 20) begin
            queue_op(OP_TICK);
        end
        queue_event(OP_CARD, id, nbytes, 4'($urandom_range(15)));
        right = ($urandom_range(99) < 70);
        i = 0;
        while (i < PIN_DIGITS) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                repeat ($urandom_range(1, 6)) queue_op(OP_TICK);
            end else if (pick < 9) begin
                queue_event(OP_KEY, $urandom, 4'($urandom_range(15)),
                            4'($urandom_range(KEY_LETTER_A, KEY_LETTER_D)));
            end else if (pick < 12) begin
                queue_event(OP_KEY, $urandom, 4'($urandom_range(15)), KEY_STAR);
                i = 0;
            end else if (pick < 14) begin
                queue_event(OP_KEY, $urandom, 4'($urandom_range(15)), KEY_HASH);
                return;
            end else if (pick < 16) begin
                // Cancel by opening the door, and usually close it again.
                queue_op(OP_BUTTON);
                if ($urandom_range(99) < 70) begin
                    queue_op(OP_BUTTON);
                end
                return;
            end else begin
                d = pin[4 * (PIN_DIGITS - 1 - i) +: 4];
                if (!right || d > KEY_DIGIT_MAX) begin
                    d = 4'($urandom_range(9));
                end
                queue_event(OP_KEY, $urandom, 4'($urandom_range(15)), d);
                i++;
            end
        end
        // Close the door after a likely grant; now and then toggle it regardless.
        if ($urandom_range(99) < (right ? 85 : 10)) begin
            queue_op(OP_BUTTON);
        end
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned start;
        start = queued_count;
        while (queued_count - start < count) begin
            if ($urandom_range(99) < 12) begin
                queue_noise();
            end else begin
                queue_session();
            end
        end
    endtask

    // Test sequence.
    initial begin
        logic [31:0] shared_id;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings, no idling: walk through every kind of event but a reader fault.
        queue_op(OP_TICK);
        queue_event(OP_CARD, set_card_a_id, 4'd0, 4'd0);
        queue_event(OP_CARD, 32'hA5A5_5A5A, 4'd15, 4'd0);
        queue_event(OP_CARD, set_card_b_id, CARD_ID_LEN, 4'd0);
        queue_event(OP_KEY, 32'd0, 4'd0, KEY_LETTER_D);
        queue_event(OP_KEY, 32'd0, 4'd0, 4'd1);
        queue_event(OP_KEY, 32'd0, 4'd0, KEY_STAR);
        queue_event(OP_KEY, 32'd0, 4'd0, KEY_HASH);
        queue_event(OP_KEY, 32'd0, 4'd0, 4'd9);
        queue_event(OP_CARD, set_card_a_id, CARD_ID_LEN, 4'd0);
        queue_event(OP_KEY, 32'd0, 4'd0, 4'd1);
        queue_event(OP_KEY, 32'd0, 4'd0, 4'd2);
        queue_event(OP_KEY, 32'd0, 4'd0, 4'd3);
        queue_event(OP_KEY, 32'd0, 4'd0, 4'd4);
        queue_event(OP_CARD, set_card_a_id, CARD_ID_LEN, 4'd0);
        queue_op(OP_BUTTON);
        queue_event(OP_CARD, set_card_b_id, CARD_ID_LEN, 4'd0);
        queue_op(OP_BUTTON);
        queue_op(OP_BUTTON);
        queue_op(OP_UNDEFINED);
        queue_random(300);
        wait_idle();

        // Extreme settings with a one-tick timeout; the sender idles.
        set_lock(32'd0, 32'hFFFF_FFFF, 16'h0000, 16'h9999, 32'd1);
        send_gap_pct = 53;
        queue_event(OP_CARD, 32'hFFFF_FFFF, CARD_ID_LEN, 4'd0);
        queue_op(OP_TICK);
        queue_op(OP_TICK);
        queue_event(OP_CARD, 32'd0, CARD_ID_LEN, 4'd0);
        repeat (PIN_DIGITS) queue_event(OP_KEY, 32'd0, 4'd0, 4'd0);
        queue_op(OP_BUTTON);
        queue_random(300);
        wait_idle();

        // Random ids and decimal PINs, short timeout; the receiver stalls.
        set_lock($urandom, $urandom, random_bcd(), random_bcd(), 32'd8);
        send_gap_pct   = 0;
        sink_stall_pct = 53;
        queue_random(150);
        // Hold off the sender until the block has drained completely.
        wait_idle();
        queue_random(150);
        wait_idle();

        // Arbitrary PIN nibbles and the longest timeout; both sides idle.
        set_lock($urandom, $urandom, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF);
        send_gap_pct   = 26;
        sink_stall_pct = 26;
        queue_random(300);
        wait_idle();

        // Both cards share one id, so the first card wins; then a fault locks the block for the rest of the run.
        shared_id = $urandom;
        set_lock(shared_id, shared_id, random_bcd(), random_bcd(),
                 32'($urandom_range(2, 40)));
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        queue_random(300);
        queue_event(OP_CARD, shared_id, CARD_ID_LEN, 4'd0);
        queue_event(OP_KEY, 32'd0, 4'd0, 4'd7);
        queue_op(OP_FAULT);
        queue_op(OP_BUTTON);
        queue_event(OP_CARD, shared_id, CARD_ID_LEN, 4'd0);
        queue_event(OP_KEY, 32'd0, 4'd0, 4'd3);
        repeat (40) queue_op(3'($urandom_range(7)));
        wait_idle();
        repeat (10) @(negedge aclk);

        $display("Checked %0d results across five lock settings and four idling patterns.",
                 checked_count);
        $display("Seen: %0d granted, %0d denied, %0d cleared, %0d cancelled, %0d faults.",
                 status_seen[ST_GRANTED], status_seen[ST_DENIED], status_seen[ST_CLEARED],
                 status_seen[ST_CANCELLED], status_seen[ST_FAULT]);
        if (error_count == 0) begin
            $display("PASS card_and_pin_access_controller");
        end else begin
            $display("%0d mismatches.", error_count);
            $display("FAIL card_and_pin_access_controller");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/cpac_pkg.sv
src/cpac_regs.sv
src/cpac_in_reg.sv
src/cpac_core.sv
src/cpac_out_reg.sv
src/card_and_pin_access_controller.sv
verif/card_and_pin_access_controller_test.sv
